>>> rtl/nul_list_json_encoder_macros.svh
// assertion macros shared by the encoder
`ifndef NUL_LIST_JSON_ENCODER_MACROS_SVH
`define NUL_LIST_JSON_ENCODER_MACROS_SVH

// clocked assertion, off while reset is high
`define NLJE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication into the next clock, off while reset is high
`define NLJE_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/nlje_pkg.sv
package nlje_pkg;

  localparam int NUM_SLOTS = 14;
  localparam int SLOT_W    = 4;

  // fixed slot positions of one command
  localparam logic [SLOT_W-1:0] SLOT_OPEN  = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_COMMA = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_QUOTE = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_BODY  = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_CLOSE = 4'd9;
  localparam logic [SLOT_W-1:0] SLOT_TAIL  = 4'd13;

  localparam logic [1:0] MODE_ARRAY  = 2'd0;
  localparam logic [1:0] MODE_OBJECT = 2'd1;
  localparam logic [1:0] MODE_STRING = 2'd2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_EQUALS = 8'h3d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       block_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0]       mask;
    logic [NUM_SLOTS-1:0][7:0]  bytes;
  } cmd_t;

  // short escape letter, zero when the byte has none
  function automatic logic [7:0] esc_code(input logic [7:0] c);
    logic [7:0] e;
    unique case (c)
      8'h22:   e = CH_QUOTE;
      8'h5c:   e = CH_BSLASH;
      8'h0a:   e = 8'h6e;
      8'h0d:   e = 8'h72;
      8'h09:   e = 8'h74;
      8'h08:   e = 8'h62;
      8'h0c:   e = 8'h66;
      default: e = 8'h00;
    endcase
    return e;
  endfunction

  // lowercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? (CH_ZERO + {4'h0, nib}) : (8'h57 + {4'h0, nib});
  endfunction

endpackage

>>> rtl/nlje_front.sv
module nlje_front import nlje_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_item_t   in_data,
  input  logic [1:0] format_mode,
  output logic       push,
  output cmd_t       cmd
);

  logic block_started, entry_open, past_equals, any_entry_sent;
  logic block_started_next, entry_open_next, past_equals_next, any_entry_sent_next;

  logic [7:0] c;
  logic       last, kv, is_str, is_sep, pe_cur, pe_after;
  logic [7:0] e;
  logic [5:0]       esc_mask;
  logic [5:0][7:0]  esc_bytes;

  assign push   = in_valid && !in_stall;
  assign c      = in_data.in_byte;
  assign last   = in_data.block_end;
  assign kv     = (format_mode == MODE_OBJECT);
  assign is_str = format_mode[1];
  assign e      = esc_code(c);
  assign pe_cur = entry_open && past_equals;
  assign is_sep = kv && !pe_cur && (c == CH_EQUALS);
  assign pe_after = pe_cur || is_sep;

  // escaped form of the byte, body slots
  always_comb begin
    esc_mask  = '0;
    esc_bytes = '0;
    if (e != 8'h00) begin
      esc_mask     = 6'b000011;
      esc_bytes[0] = CH_BSLASH;
      esc_bytes[1] = e;
    end else if (c < CTRL_LIMIT) begin
      esc_mask     = 6'b111111;
      esc_bytes[0] = CH_BSLASH;
      esc_bytes[1] = CH_U;
      esc_bytes[2] = CH_ZERO;
      esc_bytes[3] = CH_ZERO;
      esc_bytes[4] = hex_char(c[7:4]);
      esc_bytes[5] = hex_char(c[3:0]);
    end else begin
      esc_mask     = 6'b000001;
      esc_bytes[0] = c;
    end
  end

  always_comb begin
    logic close_en;
    logic close_kv;
    close_en = 1'b0;
    close_kv = 1'b0;
    cmd = '0;
    block_started_next  = block_started;
    entry_open_next     = entry_open;
    past_equals_next    = past_equals;
    any_entry_sent_next = any_entry_sent;

    if (is_str) begin
      if (!block_started) begin
        cmd.mask[SLOT_OPEN]  = 1'b1;
        cmd.bytes[SLOT_OPEN] = CH_QUOTE;
      end
      for (int i = 0; i < 6; i++) begin
        cmd.mask[int'(SLOT_BODY) + i]  = esc_mask[i];
        cmd.bytes[int'(SLOT_BODY) + i] = esc_bytes[i];
      end
      if (last) begin
        cmd.mask[SLOT_TAIL]  = 1'b1;
        cmd.bytes[SLOT_TAIL] = CH_QUOTE;
      end
      block_started_next = 1'b1;
    end else begin
      if (!block_started) begin
        cmd.mask[SLOT_OPEN]  = 1'b1;
        cmd.bytes[SLOT_OPEN] = kv ? CH_LBRACE : CH_LBRACK;
      end
      block_started_next = 1'b1;
      if (c == 8'h00) begin
        if (entry_open) begin
          close_en = 1'b1;
          close_kv = kv && !past_equals;
        end else if (!last) begin
          // empty entry in the middle of the block
          cmd.mask[SLOT_COMMA]  = any_entry_sent;
          cmd.bytes[SLOT_COMMA] = CH_COMMA;
          cmd.mask[SLOT_QUOTE]  = 1'b1;
          cmd.bytes[SLOT_QUOTE] = CH_QUOTE;
          close_en = 1'b1;
          close_kv = kv;
          any_entry_sent_next = 1'b1;
        end
        entry_open_next  = 1'b0;
        past_equals_next = 1'b0;
      end else begin
        if (!entry_open) begin
          cmd.mask[SLOT_COMMA]  = any_entry_sent;
          cmd.bytes[SLOT_COMMA] = CH_COMMA;
          cmd.mask[SLOT_QUOTE]  = 1'b1;
          cmd.bytes[SLOT_QUOTE] = CH_QUOTE;
        end
        if (is_sep) begin
          cmd.mask[int'(SLOT_BODY) + 0]  = 1'b1;
          cmd.bytes[int'(SLOT_BODY) + 0] = CH_QUOTE;
          cmd.mask[int'(SLOT_BODY) + 1]  = 1'b1;
          cmd.bytes[int'(SLOT_BODY) + 1] = CH_COLON;
          cmd.mask[int'(SLOT_BODY) + 2]  = 1'b1;
          cmd.bytes[int'(SLOT_BODY) + 2] = CH_QUOTE;
        end else begin
          for (int i = 0; i < 6; i++) begin
            cmd.mask[int'(SLOT_BODY) + i]  = esc_mask[i];
            cmd.bytes[int'(SLOT_BODY) + i] = esc_bytes[i];
          end
        end
        if (last) begin
          close_en = 1'b1;
          close_kv = kv && !pe_after;
        end
        entry_open_next     = 1'b1;
        past_equals_next    = pe_after;
        any_entry_sent_next = 1'b1;
      end
      if (close_en) begin
        cmd.mask[SLOT_CLOSE]  = 1'b1;
        cmd.bytes[SLOT_CLOSE] = CH_QUOTE;
        if (close_kv) begin
          cmd.mask[int'(SLOT_CLOSE) + 1]  = 1'b1;
          cmd.bytes[int'(SLOT_CLOSE) + 1] = CH_COLON;
          cmd.mask[int'(SLOT_CLOSE) + 2]  = 1'b1;
          cmd.bytes[int'(SLOT_CLOSE) + 2] = CH_QUOTE;
          cmd.mask[int'(SLOT_CLOSE) + 3]  = 1'b1;
          cmd.bytes[int'(SLOT_CLOSE) + 3] = CH_QUOTE;
        end
      end
      if (last) begin
        cmd.mask[SLOT_TAIL]  = 1'b1;
        cmd.bytes[SLOT_TAIL] = kv ? CH_RBRACE : CH_RBRACK;
      end
    end

    if (last) begin
      block_started_next  = 1'b0;
      entry_open_next     = 1'b0;
      past_equals_next    = 1'b0;
      any_entry_sent_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_started  <= 1'b0;
      entry_open     <= 1'b0;
      past_equals    <= 1'b0;
      any_entry_sent <= 1'b0;
    end else if (push) begin
      block_started  <= block_started_next;
      entry_open     <= entry_open_next;
      past_equals    <= past_equals_next;
      any_entry_sent <= any_entry_sent_next;
    end
  end

endmodule

>>> rtl/nlje_queue.sv
module nlje_queue import nlje_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wr_cmd,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/nlje_back.sv
module nlje_back import nlje_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [SLOT_W-1:0]    idx;
  logic [NUM_SLOTS-1:0] avail;
  logic [SLOT_W-1:0]    sel;
  logic                 more;
  logic                 load;

  // slots still to go in the head command
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      avail[i] = cmd.mask[i] && (SLOT_W'(i) >= idx);
    end
  end

  // lowest pending slot, and whether any follows it
  always_comb begin
    sel  = '0;
    more = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (avail[i]) sel = SLOT_W'(i);
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (avail[i] && (SLOT_W'(i) > sel)) more = 1'b1;
    end
  end

  assign load = cmd_valid && (!out_valid || !out_stall);
  assign pop  = load && !more;

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.out_byte <= cmd.bytes[sel];
      out_data.out_last <= !more;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      out_valid <= load || (out_valid && out_stall);
      if (load) begin
        idx <= more ? sel + 1'b1 : '0;
      end
    end
  end

endmodule

>>> rtl/nul_list_json_encoder.sv
// NUL-separated list to JSON text encoder. Raw bytes enter one per input
// transaction (block_end marks the final byte of a block) and JSON text
// leaves one byte per output transaction, out_last marking the final byte
// that an input byte produced; every input byte gives 1 to 13 output bytes.
// format_mode picks a string array (0), a key=value object (1) or one
// escaped string (2 or 3); write it only between transactions. The output
// side sends one byte per clock while out_stall is low. The input side
// takes one byte per clock as long as the command queue (QUEUE_DEPTH
// entries) has room; that queue decouples the classifier from the byte
// sequencer, so a stalled output does not block input until the queue
// fills. An accepted byte is written into the command queue, and its
// output bytes leave from the registered output of the sequencer.
`include "nul_list_json_encoder_macros.svh"

module nul_list_json_encoder import nlje_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  logic [1:0] format_mode;
  logic       push;
  cmd_t       wr_cmd;
  logic       q_valid;
  cmd_t       q_head;
  logic       pop;

  // mode register, taken once per write strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode <= MODE_ARRAY;
    end else if (cfg_we) begin
      format_mode <= cfg_data;
    end
  end

  // front: classify each byte into a slot command, tracks entry state
  nlje_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .format_mode (format_mode),
    .push        (push),
    .cmd         (wr_cmd)
  );

  // command queue between classifier and sequencer
  nlje_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_cmd    (wr_cmd),
    .pop       (pop),
    .full      (in_stall),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // back: walk the enabled slots, one output byte per clock while not stalled
  nlje_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // an accepted byte always leaves work in the queue
  `NLJE_ASSERT_NEXT(a_push_queued, push, q_valid, "accepted byte not queued")
  // every queued command produces at least one byte
  `NLJE_ASSERT(a_cmd_nonempty, !q_valid || (q_head.mask != '0), "empty command queued")
  // a non-final byte is followed by more bytes of the same transaction
  `NLJE_ASSERT_NEXT(a_more_follows, out_valid && !out_data.out_last, out_valid,
    "output gap inside one transaction")

endmodule
